// ===== hdl/bre_pkg.sv =====
// shared types and constants of the exp-golomb bit reader
package bre_pkg;

  localparam int STORE_BYTES_DEF   = 1024;
  localparam int MAX_RUN_BYTES_DEF = 64;

  // window and read limits
  localparam int WIN_BITS  = 32;
  localparam int MAX_TAKE  = 24;
  localparam int PART_MASK = 'h07;

  localparam int TYPE_W  = 3;
  localparam int INDEX_W = 10;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 11;
  localparam int COUNT_W = 10;
  localparam int VALUE_W = 25;
  localparam int POS_W   = 6;
  localparam int TAKE_W  = 5;

  // request codes
  localparam logic [TYPE_W-1:0] REQ_START = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_LOAD  = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_BITS  = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_UE    = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_RUN   = 3'd4;

  typedef struct packed {
    logic [TYPE_W-1:0]  req_type;
    logic [INDEX_W-1:0] byte_index;
    logic [BYTE_W-1:0]  byte_value;
    logic [LEN_W-1:0]   buffer_length;
    logic [COUNT_W-1:0] bit_count;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
    logic               end_flag;
    logic               last;
  } res_t;

endpackage

// ===== hdl/bitstream_reader_exp_golomb_unit.sv =====
// top level of the exp-golomb bit reader: stream ports, byte store, output register
//
//  channel  dir  handshake              payload
//  s_axis   in   tvalid/tready          tuser: req_type; tdata: index, byte, length, count
//  m_axis   out  tvalid/tready, tlast   tdata: value, status, end_flag
//
// start and load: the request moves the sequencer to its emit state, then the result enters the
// output register; a bit read adds an extraction state and a fill state per byte pulled into the
// window from the byte store (registered read). exp-golomb: one extraction step per prefix bit
// (stop bit included) and one for a nonempty suffix, plus refills. byte runs: each byte takes
// the run state and an extraction or store-read state, plus refills; a new request is taken while
// the last result waits in the output register. reset is synchronous; the store is not cleared.
module bitstream_reader_exp_golomb_unit #(
  parameter int STORE_BYTES   = bre_pkg::STORE_BYTES_DEF,
  parameter int MAX_RUN_BYTES = bre_pkg::MAX_RUN_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // byte_index[9:0], byte_value[17:10], buffer_length[28:18], bit_count[38:29], zero
  input  logic [39:0] s_axis_tdata,
  // req_type[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // value[24:0], status[25], end_flag[26], zero
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int ADDR_W = $clog2(STORE_BYTES);

  bre_pkg::req_t req;
  bre_pkg::res_t res;

  logic                         wr_en;
  logic [ADDR_W-1:0]            wr_addr;
  logic [bre_pkg::BYTE_W-1:0]   wr_data;
  logic                         rd_en;
  logic [ADDR_W-1:0]            rd_addr;
  logic [bre_pkg::BYTE_W-1:0]   rd_data;
  logic                         res_valid;
  logic                         res_ready;

  logic                         out_valid;
  bre_pkg::res_t                out_res;

  assign req = '{req_type:      s_axis_tuser,
                 byte_index:    s_axis_tdata[9:0],
                 byte_value:    s_axis_tdata[17:10],
                 buffer_length: s_axis_tdata[28:18],
                 bit_count:     s_axis_tdata[38:29]};

  bre_ram #(
    .WIDTH (bre_pkg::BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bre_ctrl #(
    .STORE_BYTES   (STORE_BYTES),
    .MAX_RUN_BYTES (MAX_RUN_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .req       (req),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register frees itself in the cycle its result is taken
  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_res.end_flag, out_res.status, out_res.value};
  assign m_axis_tlast  = out_res.last;

endmodule

// ===== hdl/bre_ram.sv =====
// generic simple dual-port ram with registered read
module bre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/bre_ctrl.sv =====
// request sequencer: window refill, bit extraction, exp-golomb and byte runs
module bre_ctrl #(
  parameter int STORE_BYTES   = bre_pkg::STORE_BYTES_DEF,
  parameter int MAX_RUN_BYTES = bre_pkg::MAX_RUN_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  bre_pkg::req_t                  req,
  output logic                           wr_en,
  output logic [$clog2(STORE_BYTES)-1:0] wr_addr,
  output logic [bre_pkg::BYTE_W-1:0]     wr_data,
  output logic                           rd_en,
  output logic [$clog2(STORE_BYTES)-1:0] rd_addr,
  input  logic [bre_pkg::BYTE_W-1:0]     rd_data,
  output logic                           res_valid,
  input  logic                           res_ready,
  output bre_pkg::res_t                  res
);

  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int RUN_W  = $clog2(MAX_RUN_BYTES + 1);
  localparam int LEN_W  = bre_pkg::LEN_W;
  localparam int POS_W  = bre_pkg::POS_W;
  localparam int TAKE_W = bre_pkg::TAKE_W;
  localparam int VAL_W  = bre_pkg::VALUE_W;
  localparam int AVL_W  = LEN_W + 3;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_TAKE = 6'b000010,
    S_FILL = 6'b000100,
    S_RUN  = 6'b001000,
    S_RUNW = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state;

  logic [bre_pkg::WIN_BITS-1:0] window;
  logic [POS_W-1:0]             pos;
  logic [LEN_W-1:0]             next_byte;
  logic [LEN_W-1:0]             len_in_use;
  logic                         end_mark;
  logic                         started;

  logic [bre_pkg::TYPE_W-1:0]   op;
  logic [TAKE_W-1:0]            n;
  logic [TAKE_W-1:0]            zeros;
  logic                         ue_suffix;
  logic [RUN_W-1:0]             run_left;
  logic [2:0]                   rest;

  logic [VAL_W-1:0]             res_value;
  logic                         res_status;
  logic                         res_last;

  logic [POS_W-1:0]             avail;
  logic [POS_W-1:0]             shamt;
  logic [bre_pkg::WIN_BITS-1:0] win_sh;
  logic [VAL_W-1:0]             take_mask;
  logic [bre_pkg::MAX_TAKE-1:0] take_val;
  logic                         have_bits;
  logic                         out_of_bytes;
  logic                         win_empty;
  logic [AVL_W-1:0]             bits_left;
  logic [VAL_W-1:0]             ue_value;
  logic [bre_pkg::BYTE_W-1:0]   part_byte;
  logic                         run_final;

  always_comb begin
    avail        = POS_W'(bre_pkg::WIN_BITS) - pos;
    shamt        = avail - {1'b0, n};
    win_sh       = window >> shamt;
    take_mask    = (VAL_W'(1) << n) - VAL_W'(1);
    take_val     = win_sh[bre_pkg::MAX_TAKE-1:0] & take_mask[bre_pkg::MAX_TAKE-1:0];
    have_bits    = avail >= {1'b0, n};
    out_of_bytes = next_byte >= len_in_use;
    win_empty    = pos == POS_W'(bre_pkg::WIN_BITS);
    // buffered bits plus bytes not yet pulled into the window
    bits_left    = AVL_W'(avail) + {len_in_use - next_byte, 3'b000};
    ue_value     = ((VAL_W'(1) << zeros) - VAL_W'(1)) + VAL_W'(take_val);
    part_byte    = take_val[bre_pkg::BYTE_W-1:0] << (4'd8 - {1'b0, rest});
    run_final    = (run_left == RUN_W'(1)) && (rest == 3'd0);
  end

  assign req_ready = state == S_IDLE;
  assign res_valid = state == S_EMIT;
  assign res       = '{value: res_value, status: res_status, end_flag: end_mark,
                       last: res_last};

  assign wr_en   = req_valid && req_ready && (req.req_type == bre_pkg::REQ_LOAD) &&
                   ({22'd0, req.byte_index} < 32'(STORE_BYTES));
  assign wr_addr = ADDR_W'(req.byte_index);
  assign wr_data = req.byte_value;

  assign rd_en   = ((state == S_TAKE) && !have_bits && !out_of_bytes) ||
                   ((state == S_RUN) && (run_left != '0) && win_empty);
  assign rd_addr = ADDR_W'(next_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      window     <= '0;
      pos        <= '0;
      next_byte  <= '0;
      len_in_use <= '0;
      end_mark   <= 1'b0;
      started    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op         <= req.req_type;
            res_value  <= '0;
            res_status <= 1'b0;
            res_last   <= 1'b1;
            state      <= S_EMIT;
            case (req.req_type)
              bre_pkg::REQ_START: begin
                next_byte <= '0;
                pos       <= POS_W'(bre_pkg::WIN_BITS);
                window    <= '0;
                end_mark  <= 1'b0;
                started   <= 1'b1;
                if ({21'd0, req.buffer_length} > 32'(STORE_BYTES)) begin
                  len_in_use <= LEN_W'(STORE_BYTES);
                end else begin
                  len_in_use <= req.buffer_length;
                end
              end
              bre_pkg::REQ_BITS: begin
                if (req.bit_count == '0) begin
                  end_mark <= end_mark;
                end else if (!started ||
                             {22'd0, req.bit_count} > 32'(bre_pkg::MAX_TAKE)) begin
                  end_mark <= 1'b1;
                end else if (!end_mark) begin
                  n     <= TAKE_W'(req.bit_count);
                  state <= S_TAKE;
                end
              end
              bre_pkg::REQ_UE: begin
                if (end_mark) begin
                  end_mark <= 1'b1;
                end else if (!started) begin
                  end_mark <= 1'b1;
                end else begin
                  n         <= TAKE_W'(1);
                  zeros     <= '0;
                  ue_suffix <= 1'b0;
                  state     <= S_TAKE;
                end
              end
              bre_pkg::REQ_RUN: begin
                if ({22'd0, req.bit_count} > 32'(MAX_RUN_BYTES * 8)) begin
                  end_mark   <= 1'b1;
                  res_status <= 1'b1;
                end else if (req.bit_count == '0) begin
                  end_mark <= end_mark;
                end else if (!started || end_mark || (next_byte > len_in_use) ||
                             ({4'd0, req.bit_count} > bits_left)) begin
                  end_mark   <= 1'b1;
                  res_status <= 1'b1;
                end else begin
                  run_left <= RUN_W'(req.bit_count >> 3);
                  rest     <= 3'(req.bit_count & 10'(bre_pkg::PART_MASK));
                  state    <= S_RUN;
                end
              end
              default: begin
                end_mark <= end_mark;
              end
            endcase
          end
        end

        S_TAKE: begin
          if (have_bits) begin
            pos <= pos + POS_W'(n);
            case (op)
              bre_pkg::REQ_BITS: begin
                res_value <= VAL_W'(take_val);
                state     <= S_EMIT;
              end
              bre_pkg::REQ_UE: begin
                if (ue_suffix) begin
                  res_value <= ue_value;
                  state     <= S_EMIT;
                end else if (take_val[0]) begin
                  // stop bit found, a zero-length prefix has no suffix
                  if (zeros == '0) begin
                    state <= S_EMIT;
                  end else begin
                    ue_suffix <= 1'b1;
                    n         <= zeros;
                  end
                end else if (zeros >= TAKE_W'(bre_pkg::MAX_TAKE)) begin
                  end_mark <= 1'b1;
                  state    <= S_EMIT;
                end else begin
                  zeros <= zeros + TAKE_W'(1);
                end
              end
              bre_pkg::REQ_RUN: begin
                if (run_left != '0) begin
                  res_value <= VAL_W'(take_val[bre_pkg::BYTE_W-1:0]);
                  res_last  <= run_final;
                  run_left  <= run_left - RUN_W'(1);
                end else begin
                  // trailing partial byte, left-aligned
                  res_value <= VAL_W'(part_byte);
                  res_last  <= 1'b1;
                  rest      <= 3'd0;
                end
                state <= S_EMIT;
              end
              default: begin
                state <= S_EMIT;
              end
            endcase
          end else if (out_of_bytes) begin
            end_mark  <= 1'b1;
            res_value <= '0;
            res_last  <= 1'b1;
            state     <= S_EMIT;
          end else begin
            state <= S_FILL;
          end
        end

        S_FILL: begin
          window    <= {window[bre_pkg::WIN_BITS-9:0], rd_data};
          pos       <= pos - POS_W'(8);
          next_byte <= next_byte + LEN_W'(1);
          state     <= S_TAKE;
        end

        S_RUN: begin
          if (run_left != '0) begin
            // an empty window passes whole bytes straight from the store
            if (win_empty) begin
              state <= S_RUNW;
            end else begin
              n     <= TAKE_W'(8);
              state <= S_TAKE;
            end
          end else if (rest != 3'd0) begin
            n     <= TAKE_W'(rest);
            state <= S_TAKE;
          end else begin
            state <= S_IDLE;
          end
        end

        S_RUNW: begin
          res_value <= VAL_W'(rd_data);
          res_last  <= run_final;
          run_left  <= run_left - RUN_W'(1);
          next_byte <= next_byte + LEN_W'(1);
          state     <= S_EMIT;
        end

        S_EMIT: begin
          if (res_ready) begin
            state <= res_last ? S_IDLE : S_RUN;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
